// ----- src/srpt_link_pacer_unit_macros.svh -----
// assertion helpers
`ifndef SRPT_LINK_PACER_UNIT_MACROS_SVH
`define SRPT_LINK_PACER_UNIT_MACROS_SVH
`define SLP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assertion failed");
`define SLP_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed");
`endif

// ----- src/slp_pkg.sv -----
`default_nettype none
package slp_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [1:0] CMD_CHECK = 2'd0;
	localparam logic [1:0] CMD_ADD = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_SELECT = 2'd3;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_QFULL = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_TFULL = 3'd3;
	localparam logic [2:0] ST_DUP = 3'd4;
	localparam logic [2:0] ST_NOTFOUND = 3'd5;
	localparam logic [1:0] REG_CPM = 2'd0;
	localparam logic [1:0] REG_MAXQ = 2'd1;
	localparam logic [1:0] REG_SHARE = 2'd2;
	localparam logic [1:0] REG_NOTHR = 2'd3;
	localparam logic [11:0] CREDIT_FULL = 12'd1000;
	// 1e6 = 64 * 15625; floor(x / 15625) = (x * RECIP) >> 56 for x < 2^42
	localparam logic [42:0] RECIP = 43'(((64'd1 << 56) + 64'd15624) / 64'd15625);

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] now;
		logic [15:0] pkt_len;
		logic        force_req;
		logic [31:0] message_id;
		logic [30:0] msg_remain;
		logic [63:0] start_time;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        allowed;
		logic        chosen_valid;
		logic [31:0] chosen_id;
		logic        chosen_by_age;
		logic [5:0]  occupancy;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch item, clear scan
		logic scan_step; // one table entry per cycle
		logic div_step;  // one partial product per cycle
		logic finish;    // commit state and build result
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic [1:0] command;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- src/slp_datapath.sv -----
`default_nettype none
module slp_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire slp_pkg::item_t  item,
	input  wire slp_pkg::dp_cmd_t cmd,
	output slp_pkg::dp_stat_t    stat,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_idx,
	input  wire logic [31:0]     cfg_data,
	output slp_pkg::result_t     result
);
	import slp_pkg::*;

	logic [31:0] cpm_q, maxq_q;
	logic [9:0]  share_q;
	logic        nothr_q;
	logic [63:0] idle_q;
	logic [11:0] credit_q;
	logic [CNT_W-1:0] count_q;

	logic [31:0] id_q   [TABLE_DEPTH];
	logic [30:0] rem_q  [TABLE_DEPTH];
	logic [63:0] age_q  [TABLE_DEPTH];

	item_t it_q;
	logic [CNT_W-1:0] scan_q;
	logic found_q;
	logic [IDX_W-1:0] found_at_q;
	logic [CNT_W-1:0] ins_at_q;
	logic ins_set_q;
	logic [IDX_W-1:0] old_at_q;
	logic [63:0] old_age_q;
	logic [47:0] prod_q;
	logic [84:0] acc_q;
	logic [2:0]  dcnt_q;

	logic [IDX_W-1:0] sidx;
	assign sidx = scan_q[IDX_W-1:0];
	assign stat.scan_done = (scan_q >= count_q);
	assign stat.div_done = (dcnt_q == 3'd0);
	assign stat.command = it_q.command;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q <= 32'd161600;
			maxq_q <= 32'd4000;
			share_q <= 10'd50;
			nothr_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CPM: cpm_q <= cfg_data;
				REG_MAXQ: maxq_q <= cfg_data;
				REG_SHARE: share_q <= (cfg_data[9:0] > 10'd1000) ? 10'd1000 : cfg_data[9:0];
				REG_NOTHR: nothr_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// divide by 1e6: (prod >> 6) * RECIP, split into four 21x22 products
	logic [41:0] xq;
	logic [20:0] mul_a;
	logic [21:0] mul_b;
	logic [42:0] pp;
	logic [84:0] addend;
	assign xq = prod_q[47:6];
	assign pp = 43'(mul_a) * 43'(mul_b);

	always_comb begin
		case (dcnt_q)
			3'd4: begin
				mul_a = xq[20:0];
				mul_b = {1'b0, RECIP[20:0]};
			end
			3'd3: begin
				mul_a = xq[20:0];
				mul_b = RECIP[42:21];
			end
			3'd2: begin
				mul_a = xq[41:21];
				mul_b = {1'b0, RECIP[20:0]};
			end
			default: begin
				mul_a = xq[41:21];
				mul_b = RECIP[42:21];
			end
		endcase
	end

	always_comb begin
		case (dcnt_q)
			3'd4: addend = {42'd0, pp};
			3'd3: addend = {21'd0, pp, 21'd0};
			3'd2: addend = {21'd0, pp, 21'd0};
			default: addend = {pp, 42'd0};
		endcase
	end

	// scan / divide working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= item;
			scan_q <= '0;
			found_q <= 1'b0;
			found_at_q <= '0;
			ins_set_q <= 1'b0;
			ins_at_q <= count_q;
			old_at_q <= '0;
			old_age_q <= age_q[0];
			prod_q <= 48'(cpm_q * item.pkt_len);
			acc_q <= '0;
			dcnt_q <= 3'd4;
		end else begin
			if (cmd.scan_step) begin
				if (!found_q && id_q[sidx] == it_q.message_id) begin
					found_q <= 1'b1;
					found_at_q <= sidx;
				end
				if (!ins_set_q && rem_q[sidx] > it_q.msg_remain) begin
					ins_set_q <= 1'b1;
					ins_at_q <= scan_q;
				end
				if (age_q[sidx] < old_age_q) begin
					old_age_q <= age_q[sidx];
					old_at_q <= sidx;
				end
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.div_step) begin
				acc_q <= acc_q + addend;
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	// commit
	logic [63:0] diff;
	logic [11:0] cred_sub;
	logic        cred_out;
	assign diff = idle_q - it_q.now;
	assign cred_sub = credit_q - {2'b0, share_q};
	assign cred_out = cred_sub[11] || cred_sub == 12'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
			credit_q <= CREDIT_FULL;
			count_q <= '0;
		end else if (cmd.finish) begin
			case (it_q.command)
				CMD_CHECK:
					if (!(it_q.now + {32'd0, maxq_q} < idle_q && !it_q.force_req && !nothr_q))
						idle_q <= ((idle_q < it_q.now) ? it_q.now : idle_q) +
							{35'd0, acc_q[84:56]};
				CMD_ADD:
					if (!found_q && count_q < CNT_W'(TABLE_DEPTH))
						count_q <= count_q + 1'b1;
				CMD_REMOVE:
					if (found_q) count_q <= count_q - 1'b1;
				default:
					if (!(!diff[63] && diff >= {32'd0, maxq_q}) && count_q != '0)
						credit_q <= cred_out ? cred_sub + CREDIT_FULL : cred_sub;
			endcase
		end
	end

	// table shifts on commit
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (it_q.command == CMD_ADD && !found_q && count_q < CNT_W'(TABLE_DEPTH)) begin
					if (CNT_W'(i) == ins_at_q) begin
						id_q[i] <= it_q.message_id;
						rem_q[i] <= it_q.msg_remain;
						age_q[i] <= it_q.start_time;
					end else if (CNT_W'(i) > ins_at_q && i > 0) begin
						id_q[i] <= id_q[i-1];
						rem_q[i] <= rem_q[i-1];
						age_q[i] <= age_q[i-1];
					end
				end else if (it_q.command == CMD_REMOVE && found_q) begin
					if (IDX_W'(i) >= found_at_q && i + 1 < TABLE_DEPTH) begin
						id_q[i] <= id_q[i+1];
						rem_q[i] <= rem_q[i+1];
						age_q[i] <= age_q[i+1];
					end
				end
			end
		end
	end

	// result
	result_t r;
	always_comb begin
		r = '0;
		case (it_q.command)
			CMD_CHECK: begin
				if (it_q.now + {32'd0, maxq_q} < idle_q && !it_q.force_req && !nothr_q)
					r.status = ST_QFULL;
				else r.allowed = 1'b1;
				r.occupancy = 6'(count_q);
			end
			CMD_ADD: begin
				if (found_q) begin
					r.status = ST_DUP;
					r.occupancy = 6'(count_q);
				end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
					r.status = ST_TFULL;
					r.occupancy = 6'(count_q);
				end else r.occupancy = 6'(count_q + 1'b1);
			end
			CMD_REMOVE: begin
				if (found_q) r.occupancy = 6'(count_q - 1'b1);
				else begin
					r.status = ST_NOTFOUND;
					r.occupancy = 6'(count_q);
				end
			end
			default: begin
				r.occupancy = 6'(count_q);
				if (!diff[63] && diff >= {32'd0, maxq_q}) r.status = ST_QFULL;
				else if (count_q == '0) r.status = ST_EMPTY;
				else begin
					r.chosen_valid = 1'b1;
					r.chosen_by_age = cred_out;
					r.chosen_id = cred_out ? id_q[old_at_q] : id_q[0];
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) result <= r;
	end
endmodule
`default_nettype wire

// ----- src/slp_ctrl.sv -----
`default_nettype none
module slp_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_fire,
	output logic              in_rdy,
	input  wire logic         out_rdy,
	output logic              out_vld,
	output slp_pkg::dp_cmd_t  cmd,
	input  wire slp_pkg::dp_stat_t stat
);
	import slp_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WORK = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic out_vld_q;
	logic done;

	assign done = (stat.command == CMD_CHECK) ? stat.div_done : stat.scan_done;
	assign out_vld = out_vld_q;
	assign in_rdy = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.scan_step = (state_q == S_WORK) && !stat.scan_done;
		cmd.div_step = (state_q == S_WORK) && !stat.div_done;
		cmd.finish = (state_q == S_FIN) && (!out_vld_q || out_rdy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.finish) out_vld_q <= 1'b1;
			else if (out_rdy) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_WORK;
				S_WORK: if (done) state_q <= S_FIN;
				S_FIN: if (cmd.finish) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/srpt_link_pacer_unit.sv -----
// srpt_link_pacer_unit: link pacer and shortest-remaining-first scheduler.
// Input stream s_axis: one beat per command (check, add, remove, select).
// Output stream m_axis: exactly one result beat per input beat, in order.
// Config channel cfg_*: register index and data; write only while idle.
// Work: a check divides by one million with four partial products of a
// reciprocal multiply; table commands scan one entry per cycle over the
// occupied entries. One item is in work at a time; the next beat can be taken
// the cycle after the result is registered.
// The result register holds its beat while m_axis_tready is low; the block
// then takes one more beat, works it, and stops taking input after it finishes.
// Reset (arst_n low) restores register defaults, clears the link idle time,
// sets the credit to full and empties the table; no clearing pass needed.
`default_nettype none
module srpt_link_pacer_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// command, now, pkt_len, force_req, message_id, msg_remain, start_time
	input  wire logic [215:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status, allowed, chosen_valid, chosen_id, chosen_by_age, occupancy
	output logic [47:0]       m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import slp_pkg::*;

	item_t it;
	result_t res;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic in_fire;

	assign it.command = s_axis_tdata[1:0];
	assign it.now = s_axis_tdata[65:2];
	assign it.pkt_len = s_axis_tdata[81:66];
	assign it.force_req = s_axis_tdata[82];
	assign it.message_id = s_axis_tdata[114:83];
	assign it.msg_remain = s_axis_tdata[145:115];
	assign it.start_time = s_axis_tdata[209:146];
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign m_axis_tdata = {4'd0, res.occupancy, res.chosen_by_age, res.chosen_id,
		res.chosen_valid, res.allowed, res.status};

	slp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_rdy(s_axis_tready),
		.out_rdy(m_axis_tready), .out_vld(m_axis_tvalid), .cmd(cmd), .stat(stat)
	);

	slp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(it), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data), .result(res)
	);
endmodule
`default_nettype wire

// ----- src/slp_checker.sv -----
`default_nettype none
`include "srpt_link_pacer_unit_macros.svh"
module slp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);
	`SLP_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`SLP_ASSERT_NXT(a_no_early, clk, arst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || !$past(m_axis_tvalid) || m_axis_tready || $stable(m_axis_tvalid))
	`SLP_ASSERT_IMP(a_occ_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[47:38] <= 10'd32)
	`SLP_ASSERT_IMP(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd5)
	`SLP_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind srpt_link_pacer_unit slp_checker u_slp_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- test/tb_srpt_link_pacer_unit.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_srpt_link_pacer_unit;
	import slp_pkg::*;

	class pacer_scoreboard;
		logic [31:0] cpm;
		logic [31:0] maxq;
		logic [9:0] share;
		logic nothr;
		logic [63:0] idle;
		int credit;
		int count;
		logic [31:0] ids[TABLE_DEPTH];
		logic [30:0] lefts[TABLE_DEPTH];
		logic [63:0] ages[TABLE_DEPTH];
		result_t expected_q[$];
		int errors;

		function new();
			cpm = 161600;
			maxq = 4000;
			share = 50;
			nothr = 0;
			idle = 0;
			credit = 1000;
			count = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_CPM: cpm = val;
				REG_MAXQ: maxq = val;
				REG_SHARE: share = (val[9:0] > 10'd1000) ? 10'd1000 : val[9:0];
				REG_NOTHR: nothr = val[0];
				default: ;
			endcase
		endfunction

		function int find_id(logic [31:0] id);
			for (int i = 0; i < count; i++)
				if (ids[i] == id)
					return i;
			return -1;
		endfunction

		function void note_input(item_t it);
			result_t r;
			logic [63:0] cyc;
			logic [63:0] diff;
			int at;
			int pick;
			int pos;
			r = '0;
			case (it.command)
				CMD_CHECK: begin
					cyc = (64'(cpm) * 64'(it.pkt_len)) / 64'd1000000;
					if ((it.now + 64'(maxq)) < idle && !it.force_req && !nothr) begin
						r.status = ST_QFULL;
					end else begin
						idle = ((idle < it.now) ? it.now : idle) + cyc;
						r.allowed = 1'b1;
					end
				end
				CMD_ADD: begin
					if (find_id(it.message_id) >= 0) begin
						r.status = ST_DUP;
					end else if (count >= TABLE_DEPTH) begin
						r.status = ST_TFULL;
					end else begin
						at = 0;
						while (at < count && lefts[at] <= it.msg_remain)
							at++;
						for (int i = count; i > at; i--) begin
							ids[i] = ids[i-1];
							lefts[i] = lefts[i-1];
							ages[i] = ages[i-1];
						end
						ids[at] = it.message_id;
						lefts[at] = it.msg_remain;
						ages[at] = it.start_time;
						count++;
					end
				end
				CMD_REMOVE: begin
					pos = find_id(it.message_id);
					if (pos < 0) begin
						r.status = ST_NOTFOUND;
					end else begin
						for (int i = pos; i + 1 < count; i++) begin
							ids[i] = ids[i+1];
							lefts[i] = lefts[i+1];
							ages[i] = ages[i+1];
						end
						count--;
					end
				end
				default: begin
					diff = idle - it.now;
					if (!diff[63] && diff >= 64'(maxq)) begin
						r.status = ST_QFULL;
					end else if (count == 0) begin
						r.status = ST_EMPTY;
					end else begin
						pick = 0;
						credit -= int'(share);
						if (credit <= 0) begin
							credit += 1000;
							for (int i = 1; i < count; i++)
								if (ages[i] < ages[pick])
									pick = i;
							r.chosen_by_age = 1'b1;
						end
						r.chosen_valid = 1'b1;
						r.chosen_id = ids[pick];
					end
				end
			endcase
			r.occupancy = 6'(count);
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [47:0] d);
			result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected beat %h", d));
				return;
			end
			e = expected_q.pop_front();
			if (d[2:0] !== e.status)
				report($sformatf("status %0d exp %0d", d[2:0], e.status));
			if (d[3] !== e.allowed)
				report($sformatf("allowed %0b exp %0b", d[3], e.allowed));
			if (d[4] !== e.chosen_valid)
				report($sformatf("chosen_valid %0b exp %0b", d[4], e.chosen_valid));
			if (d[36:5] !== e.chosen_id)
				report($sformatf("chosen_id %h exp %h", d[36:5], e.chosen_id));
			if (d[37] !== e.chosen_by_age)
				report($sformatf("chosen_by_age %0b exp %0b", d[37], e.chosen_by_age));
			if (d[43:38] !== e.occupancy)
				report($sformatf("occupancy %0d exp %0d", d[43:38], e.occupancy));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [215:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	pacer_scoreboard sb;
	logic [63:0] clock_now;
	int hold_req;

	srpt_link_pacer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// receiver stall pattern, with a long hold on request
	initial begin
		int mode;
		int hold;
		m_axis_tready = 1'b0;
		mode = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if ($urandom_range(0, 63) == 0)
				mode = $urandom_range(0, 2);
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);

	function logic [215:0] pack_item(item_t it);
		return {6'b0, it.start_time, it.msg_remain, it.message_id, it.force_req,
			it.pkt_len, it.now, it.command};
	endfunction

	task send_item(item_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_item(it);
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it);
	endtask

	task idle_input(int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task write_cfg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task send_fields(logic [1:0] cmd, logic [63:0] now, logic [15:0] wb, logic frc,
			logic [31:0] id, logic [30:0] left, logic [63:0] st);
		item_t it;
		it.command = cmd;
		it.now = now;
		it.pkt_len = wb;
		it.force_req = frc;
		it.message_id = id;
		it.msg_remain = left;
		it.start_time = st;
		send_item(it);
	endtask

	function item_t random_item(int add_bias);
		item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			it.command = CMD_CHECK;
		else if (r < 30 + add_bias)
			it.command = CMD_ADD;
		else if (r < 55 + add_bias)
			it.command = CMD_REMOVE;
		else
			it.command = CMD_SELECT;
		clock_now += $urandom_range(0, 400);
		r = $urandom_range(0, 9);
		if (r < 6)
			it.now = clock_now;
		else if (r < 8)
			it.now = sb.idle + 64'($signed($urandom_range(0, 10000)) - 5000);
		else
			it.now = {$urandom, $urandom};
		it.pkt_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1600));
		it.force_req = ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 9) == 0)
			it.message_id = $urandom;
		else if (it.command == CMD_REMOVE && sb.count > 0 && $urandom_range(0, 3) != 0)
			it.message_id = sb.ids[$urandom_range(0, sb.count - 1)];
		else
			it.message_id = $urandom_range(0, 47);
		it.msg_remain = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20));
		it.start_time = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} :
			64'($urandom_range(0, 5000));
		return it;
	endfunction

	task random_phase(int n, int add_bias, bit long_hold);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && sent < n; i++) begin
				if (long_hold && sent == n / 2)
					hold_req = 600;
				send_item(random_item(add_bias));
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 15));
		end
		drain();
	endtask

	initial begin
		sb = new();
		clock_now = 64'd100000;
		hold_req = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CPM;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fields(CMD_SELECT, 64'd0, 16'd0, 1'b0, 32'd1, 31'd0, 64'd0);
		send_fields(CMD_REMOVE, 64'd0, 16'd0, 1'b0, 32'hFFFFFFFF, 31'd0, 64'd0);
		send_fields(CMD_ADD, 64'd0, 16'd0, 1'b0, 32'hFFFFFFFF, 31'h7FFFFFFF, 64'hFFFFFFFFFFFFFFFF);
		send_fields(CMD_ADD, 64'd0, 16'd0, 1'b0, 32'hFFFFFFFF, 31'd5, 64'd0);
		send_fields(CMD_ADD, 64'd0, 16'd0, 1'b0, 32'd0, 31'd0, 64'd50);
		send_fields(CMD_ADD, 64'd0, 16'd0, 1'b0, 32'd7, 31'd0, 64'd10);
		send_fields(CMD_ADD, 64'd0, 16'd0, 1'b0, 32'd8, 31'd100, 64'd0);
		send_fields(CMD_SELECT, 64'd0, 16'd0, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_CHECK, 64'd0, 16'hFFFF, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_CHECK, 64'd0, 16'hFFFF, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_CHECK, 64'd0, 16'hFFFF, 1'b1, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_SELECT, 64'd0, 16'd0, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_SELECT, 64'hFFFFFFFFFFFFFFFF, 16'd0, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_CHECK, 64'hFFFFFFFFFFFFFFFF, 16'd1, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_SELECT, 64'hFFFFFFFFFFFFFFFF, 16'd0, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_REMOVE, 64'd0, 16'd0, 1'b0, 32'd0, 31'd0, 64'd0);
		send_fields(CMD_REMOVE, 64'd0, 16'd0, 1'b0, 32'd0, 31'd0, 64'd0);
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_fields(CMD_ADD, 64'd0, 16'd0, 1'b0, 32'(100 + i), 31'(i % 4),
				64'(1000 - i));
		drain();

		random_phase(300, 40, 1'b1);

		write_cfg(REG_CPM, 32'd0);
		write_cfg(REG_MAXQ, 32'd0);
		write_cfg(REG_SHARE, 32'd0);
		write_cfg(REG_NOTHR, 32'd1);
		random_phase(300, 25, 1'b0);

		write_cfg(REG_CPM, 32'hFFFFFFFF);
		write_cfg(REG_MAXQ, 32'hFFFFFFFF);
		write_cfg(REG_SHARE, 32'd1023);
		write_cfg(REG_NOTHR, 32'd0);
		random_phase(300, 30, 1'b1);

		write_cfg(REG_CPM, 32'd161600);
		write_cfg(REG_MAXQ, 32'd4000);
		write_cfg(REG_SHARE, 32'd333);
		random_phase(300, 35, 1'b0);

		write_cfg(REG_CPM, $urandom);
		write_cfg(REG_MAXQ, 32'd100);
		write_cfg(REG_SHARE, 32'd1000);
		write_cfg(REG_NOTHR, 32'd1);
		random_phase(250, 20, 1'b0);

		write_cfg(REG_CPM, 32'd8000000);
		write_cfg(REG_MAXQ, $urandom_range(0, 20000));
		write_cfg(REG_SHARE, 32'd1);
		write_cfg(REG_NOTHR, 32'd0);
		random_phase(250, 30, 1'b0);

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
